// ----- hw/rtl/psq_pkg.sv -----
`default_nettype none
package psq_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int MAX_LEN_DEF = 64;
    localparam int FIFO_DEPTH  = 2;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_ENQ   = 2'd0,
        REQ_DEQ   = 2'd1,
        REQ_PEEK  = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_TRUNC     = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic       last_byte;
        logic [3:0] position;
        logic       return_data;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [6:0]  length;
        logic [7:0]  out_byte;
        logic        last_result;
        logic [4:0]  entries_queued;
        logic [31:0] total_queued;
    } t_out_word;

endpackage
`default_nettype wire

// ----- hw/rtl/psq_fifo.sv -----
`default_nettype none
// Small queue that decouples the front end from the back end.
module psq_fifo
    import psq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_word i_data,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_in_word      o_data
);

    t_in_word   r_mem [FIFO_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'(FIFO_DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/psq_engine.sv -----
`default_nettype none
// Back end: carries out one request at a time and emits its result words.
module psq_engine
    import psq_pkg::*;
#(
    parameter int SLOTS   = SLOTS_DEF,
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_word i_data,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_out_word     o_data
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int AW = SW + LW;

    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_ENQ, S_SHIFT, S_READ, S_STREAM, S_OUT
    } t_state;

    t_state         r_state;
    logic [SLOTS-1:0] r_busy;
    logic [6:0]     r_len [SLOTS];
    logic [SW-1:0]  r_order [SLOTS];
    logic [CW-1:0]  r_count;
    logic [31:0]    r_total;
    logic [SW-1:0]  r_fslot;
    logic           r_factive, r_frej, r_ftrunc;
    logic [7:0]     r_mem [SLOTS*MAX_LEN];
    logic [7:0]     r_rdata;
    t_in_word       r_req;
    logic [SW-1:0]  r_scan, r_dslot;
    logic [CW-1:0]  r_pos;
    logic [6:0]     r_dlen, r_idx;
    t_out_word      r_out;
    logic           r_ovalid;
    logic           w_wr;
    logic [AW-1:0]  w_waddr, w_raddr;

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    function automatic logic [AW-1:0] addr_of(logic [SW-1:0] s, logic [6:0] l);
        logic [AW-1:0] a;
        a = AW'(s) * AW'(MAX_LEN) + AW'(l);
        return a;
    endfunction

    assign w_wr    = (r_state == S_ENQ) && !r_frej && (r_len[r_fslot] < 7'(MAX_LEN));
    assign w_waddr = addr_of(r_fslot, r_len[r_fslot]);
    assign w_raddr = addr_of(r_dslot, r_idx);

    // Packet store: one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[w_waddr] <= r_req.data_byte;
        r_rdata <= r_mem[w_raddr];
    end

    // Sequencer with state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_busy    <= '0;
            r_count   <= '0;
            r_total   <= '0;
            r_fslot   <= '0;
            r_factive <= 1'b0;
            r_frej    <= 1'b0;
            r_ftrunc  <= 1'b0;
            r_ovalid  <= 1'b0;
            for (int k = 0; k < SLOTS; k++) begin
                r_len[k]   <= '0;
                r_order[k] <= '0;
            end
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_req    <= i_data;
                        r_scan   <= '0;
                        r_pos    <= CW'(i_data.position);
                        r_out.entries_queued <= 5'(r_count);
                        r_out.total_queued   <= r_total;
                        r_out.out_byte       <= '0;
                        r_out.last_result    <= 1'b1;
                        case (t_req'(i_data.req_type))
                            REQ_ENQ: begin
                                if (!r_factive) begin
                                    r_factive <= 1'b1;
                                    r_frej    <= 1'b0;
                                    r_ftrunc  <= 1'b0;
                                    if (r_count < CW'(SLOTS)) begin
                                        r_state <= S_SEARCH;
                                    end else begin
                                        r_frej  <= 1'b1;
                                        r_state <= S_ENQ;
                                    end
                                end else begin
                                    r_state <= S_ENQ;
                                end
                            end
                            REQ_DEQ, REQ_PEEK: begin
                                if ({1'b0, CW'(i_data.position)} >= {1'b0, r_count}
                                    || (SLOTS < 16 && i_data.position >= 4'(SLOTS))) begin
                                    r_out.status <= ST_NOT_FOUND;
                                    r_out.slot   <= '0;
                                    r_out.length <= '0;
                                    r_ovalid     <= 1'b1;
                                end else begin
                                    r_dslot <= r_order[SW'(i_data.position)];
                                    r_dlen  <= r_len[r_order[SW'(i_data.position)]];
                                    if (t_req'(i_data.req_type) == REQ_PEEK) begin
                                        r_out.status <= ST_OK;
                                        r_out.slot   <= 4'(r_order[SW'(i_data.position)]);
                                        r_out.length <= r_len[r_order[SW'(i_data.position)]];
                                        r_ovalid     <= 1'b1;
                                    end else begin
                                        r_state <= S_SHIFT;
                                    end
                                end
                            end
                            default: begin
                                r_busy    <= '0;
                                r_count   <= '0;
                                r_fslot   <= '0;
                                r_factive <= 1'b0;
                                r_frej    <= 1'b0;
                                r_ftrunc  <= 1'b0;
                                for (int k = 0; k < SLOTS; k++) begin
                                    r_len[k]   <= '0;
                                    r_order[k] <= '0;
                                end
                                r_out.entries_queued <= '0;
                                r_out.status <= ST_OK;
                                r_out.slot   <= '0;
                                r_out.length <= '0;
                                r_ovalid     <= 1'b1;
                            end
                        endcase
                    end
                end
                // Scan one slot a cycle for the lowest free one.
                S_SEARCH: begin
                    if (!r_busy[r_scan]) begin
                        r_fslot          <= r_scan;
                        r_busy[r_scan]   <= 1'b1;
                        r_len[r_scan]    <= '0;
                        r_order[SW'(r_count)] <= r_scan;
                        r_count          <= r_count + 1'b1;
                        r_total          <= r_total + 32'd1;
                        r_state          <= S_ENQ;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                // Store the byte if the packet is not refused and has room, and report.
                S_ENQ: begin
                    r_out.entries_queued <= 5'(r_count);
                    r_out.total_queued   <= r_total;
                    if (r_frej) begin
                        r_out.status <= ST_FULL;
                        r_out.slot   <= '0;
                        r_out.length <= '0;
                    end else if (w_wr) begin
                        r_len[r_fslot] <= r_len[r_fslot] + 7'd1;
                        r_out.status   <= r_ftrunc ? ST_TRUNC : ST_OK;
                        r_out.slot     <= 4'(r_fslot);
                        r_out.length   <= r_len[r_fslot] + 7'd1;
                    end else begin
                        r_ftrunc     <= 1'b1;
                        r_out.status <= ST_TRUNC;
                        r_out.slot   <= 4'(r_fslot);
                        r_out.length <= r_len[r_fslot];
                    end
                    if (r_req.last_byte) begin
                        r_factive <= 1'b0;
                        r_frej    <= 1'b0;
                        r_ftrunc  <= 1'b0;
                    end
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                // Close the gap in the order list, one entry a cycle.
                S_SHIFT: begin
                    if (r_pos + 1'b1 < r_count) begin
                        r_order[SW'(r_pos)] <= r_order[SW'(r_pos + 1'b1)];
                        r_pos <= r_pos + 1'b1;
                    end else begin
                        r_order[SW'(r_count - 1'b1)] <= '0;
                        r_count <= r_count - 1'b1;
                        r_busy[r_dslot] <= 1'b0;
                        r_len[r_dslot]  <= '0;
                        if (r_factive && !r_frej && r_fslot == r_dslot) begin
                            r_frej   <= 1'b1;
                            r_ftrunc <= 1'b0;
                        end
                        r_out.entries_queued <= 5'(r_count - 1'b1);
                        r_out.status <= ST_OK;
                        r_out.slot   <= 4'(r_dslot);
                        r_out.length <= r_dlen;
                        r_idx        <= '0;
                        if (r_req.return_data && (r_dlen != 7'd0)) begin
                            r_state <= S_READ;
                        end else begin
                            r_ovalid <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                // Wait for the registered read of the packet store.
                S_READ: begin
                    r_state <= S_STREAM;
                end
                S_STREAM: begin
                    if (!r_ovalid) begin
                        r_out.out_byte    <= r_rdata;
                        r_out.last_result <= (r_idx + 7'd1 == r_dlen);
                        r_ovalid          <= 1'b1;
                        r_state           <= S_OUT;
                    end
                end
                // Wait for the word to go, then fetch the next byte or, after the last, go idle.
                S_OUT: begin
                    if (i_ready) begin
                        if (r_out.last_result) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 7'd1;
                            r_state <= S_READ;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/packet_slot_queue.sv -----
`default_nettype none
// Packet slot queue. Requests enter a two-word queue and are executed one at a
// time by a sequencer. The first byte of a packet starts a scan for the lowest
// free slot; a dequeue closes the gap in the order list one entry at a time and,
// with streaming, reads each byte through the single registered read port of
// the packet store. Every result word is held in an output register until
// taken, and no new request starts while one waits.
module packet_slot_queue
    import psq_pkg::*;
#(
    parameter int SLOTS   = SLOTS_DEF,
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_word  i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_word      o_data
);

    logic     w_fvalid, w_fready;
    t_in_word w_fdata;

    // Front end: request queue.
    psq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (w_fvalid),
        .i_ready (w_fready),
        .o_data  (w_fdata)
    );

    // Back end: execution.
    psq_engine #(.SLOTS(SLOTS), .MAX_LEN(MAX_LEN)) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fvalid),
        .o_ready (w_fready),
        .i_data  (w_fdata),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
`default_nettype wire

// ----- test/packet_slot_queue_tb.sv -----
module packet_slot_queue_tb;
    import psq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT     = 16;
    localparam int MAXLEN    = 64;
    localparam int CYCLE_CAP = 2000000;

    // Prediction of the queue together with the store of expected result words.
    class queue_scoreboard;
        bit [6:0]    busy_len [NSLOT];
        bit          busy [NSLOT];
        bit [7:0]    mem [NSLOT*MAXLEN];
        bit [3:0]    order [NSLOT];
        int          count;
        bit [31:0]   accepted;
        int          fill_slot;
        bit          filling, refused, truncated;
        t_out_word   pending [$];
        int          errors;

        function void wipe();
            foreach (busy[i]) begin
                busy[i] = 0;
                busy_len[i] = 0;
                order[i] = 0;
            end
            count = 0;
            fill_slot = 0;
            filling = 0;
            refused = 0;
            truncated = 0;
        endfunction

        function void queue_word(bit [1:0] st, bit [3:0] s, bit [6:0] len,
                                 bit [7:0] b, bit lst);
            t_out_word w;
            w.status = st;
            w.slot = s;
            w.length = len;
            w.out_byte = b;
            w.last_result = lst;
            w.entries_queued = count[4:0];
            w.total_queued = accepted;
            pending.push_back(w);
        endfunction

        // Note an accepted request and predict the words it causes.
        function void note_request(t_in_word r);
            int s, len, k;
            bit [7:0] copy [MAXLEN];
            bit [1:0] st;
            case (t_req'(r.req_type))
                REQ_ENQ: begin
                    if (!filling) begin
                        filling = 1;
                        refused = 1;
                        truncated = 0;
                        if (count < NSLOT) begin
                            for (int i = 0; i < NSLOT; i++) begin
                                if (!busy[i] && refused) begin
                                    refused = 0;
                                    fill_slot = i;
                                end
                            end
                        end
                        if (!refused) begin
                            busy[fill_slot] = 1;
                            busy_len[fill_slot] = 0;
                            order[count] = fill_slot;
                            count++;
                            accepted++;
                        end
                    end
                    if (refused) begin
                        st = ST_FULL;
                        s = 0;
                        len = 0;
                    end else begin
                        s = fill_slot;
                        len = busy_len[s];
                        if (len < MAXLEN) begin
                            mem[s*MAXLEN + len] = r.data_byte;
                            len++;
                            busy_len[s] = len;
                        end else begin
                            truncated = 1;
                        end
                        st = truncated ? ST_TRUNC : ST_OK;
                    end
                    if (r.last_byte) begin
                        filling = 0;
                        refused = 0;
                        truncated = 0;
                    end
                    queue_word(st, s, len, 8'd0, 1'b1);
                end
                REQ_DEQ: begin
                    if (r.position >= count) begin
                        queue_word(ST_NOT_FOUND, 0, 0, 0, 1);
                    end else begin
                        s = order[r.position];
                        len = busy_len[s];
                        for (int i = 0; i < len; i++) copy[i] = mem[s*MAXLEN + i];
                        if (filling && !refused && fill_slot == s) begin
                            refused = 1;
                            truncated = 0;
                        end
                        busy[s] = 0;
                        busy_len[s] = 0;
                        for (int i = r.position; i + 1 < count; i++) order[i] = order[i+1];
                        order[count-1] = 0;
                        count--;
                        if (!r.return_data || len == 0) begin
                            queue_word(ST_OK, s, len, 0, 1);
                        end else begin
                            for (k = 0; k < len; k++)
                                queue_word(ST_OK, s, len, copy[k], k + 1 == len);
                        end
                    end
                end
                REQ_PEEK: begin
                    if (r.position >= count) begin
                        queue_word(ST_NOT_FOUND, 0, 0, 0, 1);
                    end else begin
                        s = order[r.position];
                        queue_word(ST_OK, s, busy_len[s], 0, 1);
                    end
                end
                default: begin
                    wipe();
                    queue_word(ST_OK, 0, 0, 0, 1);
                end
            endcase
        endfunction

        // Compare one delivered word with the oldest expectation.
        task check_word(t_out_word got);
            t_out_word want;
            if (pending.size() == 0) begin
                report("unexpected word", 0, got);
                return;
            end
            want = pending.pop_front();
            if (got.status != want.status) report("status", want, got);
            if (got.slot != want.slot) report("slot", want, got);
            if (got.length != want.length) report("length", want, got);
            if (got.out_byte != want.out_byte) report("out_byte", want, got);
            if (got.last_result != want.last_result) report("last_result", want, got);
            if (got.entries_queued != want.entries_queued) report("entries", want, got);
            if (got.total_queued != want.total_queued) report("total", want, got);
        endtask

        task report(string what, t_out_word want, t_out_word got);
            errors++;
            if (errors <= 40) $display("mismatch on %s: expected %h, got %h", what, want, got);
        endtask
    endclass

    logic      clk = 0;
    logic      rst_n = 0;
    logic      in_valid = 0;
    logic      in_ready;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_ready = 0;
    t_out_word out_word;

    queue_scoreboard board = new();
    int  cycles = 0;
    bit  quiet = 0;
    int  stall_left = 0;

    always #5 clk = ~clk;

    packet_slot_queue u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready), .i_data(in_word),
        .o_valid(out_valid), .i_ready(out_ready), .o_data(out_word)
    );

    // Receiver side: take words, stalling in random bursts.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) board.check_word(out_word);
        if (quiet) begin
            out_ready <= 1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            out_ready <= 0;
        end else begin
            out_ready <= 1;
        end
    end

    // Cycle limit.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Present one request word and hold it until taken, at times with a random gap first.
    // Valid stays high after a take so that back-to-back words need no second
    // assignment in the same time step; a gap or a pause lowers it.
    task automatic send(t_req kind, bit [7:0] b, bit lst, bit [3:0] pos, bit ret);
        t_in_word w;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        w.req_type = kind;
        w.data_byte = b;
        w.last_byte = lst;
        w.position = pos;
        w.return_data = ret;
        in_word <= w;
        in_valid <= 1;
        do @(posedge clk); while (!in_ready);
        board.note_request(w);
    endtask

    task automatic send_packet(int len, bit mark_last);
        for (int i = 0; i < len; i++)
            send(REQ_ENQ, $urandom_range(0, 255), mark_last && i == len - 1, 0, 0);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
    endtask

    int pick;

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: empty queue lookups, packets of one and of two bytes.
        send(REQ_PEEK, 0, 0, 4'd0, 0);
        send(REQ_DEQ, 0, 0, 4'd15, 1);
        send(REQ_ENQ, 8'hff, 1, 0, 0);
        send(REQ_ENQ, 8'h00, 0, 0, 0);
        send(REQ_ENQ, 8'h5a, 1, 0, 0);
        send(REQ_PEEK, 0, 0, 4'd1, 0);
        send(REQ_DEQ, 0, 0, 4'd0, 1);
        send(REQ_DEQ, 0, 0, 4'd0, 0);
        send(REQ_CLEAR, 0, 0, 0, 0);
        // Over-long packet: the tail bytes are flagged as truncated.
        send_packet(MAXLEN + 2, 1);
        send(REQ_DEQ, 0, 0, 4'd0, 1);
        // Dequeue of the packet still filling aborts it.
        send(REQ_ENQ, 8'h11, 0, 0, 0);
        send(REQ_DEQ, 0, 0, 4'd0, 1);
        send(REQ_ENQ, 8'h22, 1, 0, 0);
        // Fill every slot, then a refused packet.
        for (int p = 0; p < NSLOT; p++) send(REQ_ENQ, p, 1, 0, 0);
        send(REQ_ENQ, 8'h33, 0, 0, 0);
        send(REQ_ENQ, 8'h44, 1, 0, 0);
        send(REQ_PEEK, 0, 0, 4'd15, 0);
        send(REQ_DEQ, 0, 0, 4'd7, 0);
        // Pause until every expected word has arrived.
        drain();
        send(REQ_CLEAR, 0, 0, 0, 0);

        // Random part: mostly whole packets with lookups and removals between.
        for (int n = 0; n < 220; ) begin
            pick = $urandom_range(0, 99);
            if (n > 180) quiet = 1;
            if (pick < 45) begin
                int len;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAXLEN + 3)
                                                  : $urandom_range(1, 6);
                send_packet(len, $urandom_range(0, 15) != 0);
                n += len;
            end else if (pick < 75) begin
                send(REQ_DEQ, 0, 0, $urandom_range(0, 15), $urandom_range(0, 1));
                n++;
            end else if (pick < 97) begin
                send(REQ_PEEK, 0, 0, $urandom_range(0, 15), 0);
                n++;
            end else begin
                send(REQ_CLEAR, 0, 0, 0, 0);
                n++;
            end
        end

        drain();
        repeat (50) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
